// ===== rtl/core/rcsp_pkg.sv =====
`default_nettype none

package rcsp_pkg;

  // Command codes carried in the request
  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_GET     = 3'd1,
    CMD_PUT     = 3'd2,
    CMD_NEXT_ID = 3'd3,
    CMD_DEPTH   = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [30:0] id;
    logic        pvalid;
    logic [3:0]  link;
    logic [15:0] count;
  } entry_t;

  localparam int          GROUP_W   = 16;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [30:0] ID_MAX    = 31'h7FFF_FFFF;
  localparam logic [4:0]  DEPTH_RST = 5'd4;

endpackage

`default_nettype wire

// ===== rtl/core/refcounted_namespace_slot_pool.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       request    in_tvalid/in_tready  tdata: command, slot, parent_slot, parent_present
// out_      result     out_tvalid/out_tready tdata: status, granted_slot, value
// cfg_      register   cfg_valid/cfg_ready  cfg_data: max_depth (always ready)
//
// Get, put and next id go through accept, one read-modify-write of the slot memory, and hand-off.
// Allocate scans the free map one group of 16 slots at a time (ceil(SLOTS/16) groups at most).
// Depth check does one memory read per parent link followed.
// One request is in work at a time; a finished result waits in the output register while the
// next request is taken. Reset is synchronous; the free map clears at once, no sweep.
// A stalled output holds the sequencer in its hand-off state until the result is taken.
module refcounted_namespace_slot_pool #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] command, [6:3] slot, [10:7] parent_slot, [11] parent_present, [15:12] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [5:2] granted_slot, [36:6] value, [39:37] zero
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import rcsp_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int GRP  = GROUP_W;
  localparam int NGRP = (SLOTS + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD  = NGRP * GRP;

  state_t state_r, state_nxt;

  // Request fields
  cmd_t        in_cmd;
  logic [3:0]  in_slot;
  logic [3:0]  in_par;
  logic        in_pp;
  logic        accept;
  logic        in_slot_ok;

  // Held request
  cmd_t        cmd_r, cmd_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [3:0]  par_r, par_nxt;
  logic        pp_r, pp_nxt;

  // Scan and walk counters
  logic [GW-1:0] grp_r, grp_nxt;
  logic [4:0]  depth_r, depth_nxt;
  logic [4:0]  depth_inc;

  // Free map: one bit per slot, set while the count is nonzero
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [PAD-1:0]   busy_pad;
  logic [GRP-1:0]   grp_free;
  logic [3:0]       free_idx;
  logic             alloc_found;
  logic             last_grp;
  logic [GW+3:0]    alloc_full;
  logic [AW-1:0]    alloc_addr;

  // Slot memory
  entry_t        mem [SLOTS];
  entry_t        rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Execute-stage view
  logic [15:0] cnt;
  logic        walk_hit;
  logic        walk_stop;

  // Pending result
  status_t     res_status_r, res_status_nxt;
  logic [3:0]  res_granted_r, res_granted_nxt;
  logic [30:0] res_value_r, res_value_nxt;

  // Output register and configuration
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [39:0] out_tdata_r, out_tdata_nxt;
  logic        out_load;
  logic [4:0]  max_depth_r, max_depth_nxt;

  // Unpack the request
  assign in_cmd     = cmd_t'(in_tdata[2:0]);
  assign in_slot    = in_tdata[6:3];
  assign in_par     = in_tdata[10:7];
  assign in_pp      = in_tdata[11];
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_slot_ok = (32'(in_slot) < SLOTS);

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_load   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Pad the free map to whole groups; pad slots never look free
  always_comb begin
    busy_pad = '1;
    busy_pad[SLOTS-1:0] = busy_r;
  end

  // Pick the lowest free slot in the current group
  always_comb begin
    grp_free = ~busy_pad[grp_r*GRP +: GRP];
    free_idx = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (grp_free[i]) begin
        free_idx = 4'(i);
      end
    end
  end

  assign alloc_found = |grp_free;
  assign last_grp    = (grp_r == GW'(NGRP - 1));
  assign alloc_full  = {grp_r, free_idx};
  assign alloc_addr  = AW'(alloc_full);

  // Count of the slot under work; a slot off the free map counts zero
  assign cnt       = busy_r[slot_r] ? rd_data_r.count : 16'd0;
  assign depth_inc = 5'(depth_r + 5'd1);
  assign walk_hit  = (depth_inc >= max_depth_r);
  assign walk_stop = walk_hit || !rd_data_r.pvalid || (32'(rd_data_r.link) >= SLOTS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ALLOC: begin
              state_nxt = S_SCAN;
            end
            CMD_GET, CMD_PUT, CMD_NEXT_ID, CMD_DEPTH: begin
              if (!in_slot_ok) begin
                state_nxt = S_DONE;
              end else if (in_cmd == CMD_DEPTH && max_depth_r == 5'd0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (alloc_found || last_grp) begin
          state_nxt = S_DONE;
        end
      end
      S_EXEC: begin
        if (!(cmd_r == CMD_DEPTH && !walk_stop)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    cmd_nxt         = cmd_r;
    slot_nxt        = slot_r;
    par_nxt         = par_r;
    pp_nxt          = pp_r;
    grp_nxt         = grp_r;
    depth_nxt       = depth_r;
    busy_nxt        = busy_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    res_value_nxt   = res_value_r;
    rd_en           = 1'b0;
    rd_addr         = slot_r;
    wr_en           = 1'b0;
    wr_addr         = slot_r;
    wr_data         = rd_data_r;
    max_depth_nxt   = cfg_valid ? cfg_data : max_depth_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt         = in_cmd;
          slot_nxt        = AW'(in_slot);
          par_nxt         = in_par;
          pp_nxt          = in_pp;
          grp_nxt         = '0;
          depth_nxt       = '0;
          res_status_nxt  = ST_OK;
          res_granted_nxt = '0;
          res_value_nxt   = '0;
          unique case (in_cmd)
            CMD_ALLOC: begin
            end
            CMD_GET, CMD_PUT, CMD_NEXT_ID, CMD_DEPTH: begin
              if (!in_slot_ok) begin
                res_status_nxt = ST_ZERO;
              end else if (in_cmd == CMD_DEPTH && max_depth_r == 5'd0) begin
                res_value_nxt = 31'd1;
              end else begin
                // fetch the addressed slot
                rd_en   = 1'b1;
                rd_addr = AW'(in_slot);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (alloc_found) begin
          // claim the slot outright; no read needed
          wr_en              = 1'b1;
          wr_addr            = alloc_addr;
          wr_data.count      = 16'd1;
          wr_data.pvalid     = pp_r;
          wr_data.link       = pp_r ? par_r : 4'd0;
          wr_data.id         = 31'd1;
          busy_nxt[alloc_addr] = 1'b1;
          res_granted_nxt    = alloc_full[3:0];
        end else if (last_grp) begin
          res_status_nxt = ST_FULL;
        end else begin
          grp_nxt = GW'(grp_r + 1'b1);
        end
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_GET: begin
            if (cnt == COUNT_MAX) begin
              res_status_nxt = ST_SAT;
            end else begin
              wr_en            = 1'b1;
              wr_data.count    = 16'(cnt + 16'd1);
              busy_nxt[slot_r] = 1'b1;
            end
          end
          CMD_PUT: begin
            if (cnt == 16'd0) begin
              res_status_nxt = ST_ZERO;
            end else begin
              wr_en            = 1'b1;
              wr_data.count    = 16'(cnt - 16'd1);
              busy_nxt[slot_r] = (cnt != 16'd1);
            end
          end
          CMD_NEXT_ID: begin
            res_value_nxt = rd_data_r.id;
            if (rd_data_r.id == ID_MAX) begin
              res_status_nxt = ST_SAT;
            end else begin
              wr_en      = 1'b1;
              wr_data.id = 31'(rd_data_r.id + 31'd1);
            end
          end
          CMD_DEPTH: begin
            if (walk_stop) begin
              res_value_nxt = {30'd0, walk_hit};
            end else begin
              // follow the parent link
              rd_en     = 1'b1;
              rd_addr   = AW'(rd_data_r.link);
              depth_nxt = depth_inc;
            end
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: load the pending result, drop it once taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'd0, res_value_r, res_granted_r, res_status_r};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      out_tvalid_r <= 1'b0;
      max_depth_r  <= DEPTH_RST;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      max_depth_r  <= max_depth_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    slot_r        <= slot_nxt;
    par_r         <= par_nxt;
    pp_r          <= pp_nxt;
    grp_r         <= grp_nxt;
    depth_r       <= depth_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    res_value_r   <= res_value_nxt;
    out_tdata_r   <= out_tdata_nxt;
  end

`ifndef NO_ASSERTIONS
  // A claimed slot shows as busy right after the scan
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && alloc_found) |=> busy_r[$past(alloc_addr)])
    else $error("allocated slot not marked busy");

  // A full report only when every slot is busy
  a_full_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !alloc_found && last_grp) |-> (&busy_r))
    else $error("pool reported full with a free slot");

  // Memory never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("slot memory read and write overlap");

  // A stalled output keeps the result pending
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("pending result lost under output stall");
`endif

endmodule

`default_nettype wire
